// ----- hw/rtl/wto_pkg.sv -----
`timescale 1ns / 1ps

package wto_pkg;

  localparam int unsigned TABLE_LEN   = 4410;
  localparam int unsigned NUM_BANDS   = 8;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned STORE_DEPTH = NUM_BANDS * TABLE_LEN;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned POS_W   = $clog2(TABLE_LEN);
  localparam int unsigned PHASE_W = 29;
  localparam int unsigned SUM_W   = PHASE_W + 1;
  localparam int unsigned BAND_W  = 3;
  localparam int unsigned SAMP_W  = 16;

  localparam int unsigned FREQ_MUL = 8;
  localparam int unsigned FREQ_DIV = 100;
  localparam int unsigned BAND_DIV = (FREQ_DIV << FRAC_BITS) / FREQ_MUL;
  localparam int unsigned BAND_LIMIT = (NUM_BANDS - 1 < 7) ? NUM_BANDS - 1 : 7;

  localparam logic [PHASE_W-1:0] STEP_ONE = PHASE_W'(1) << FRAC_BITS;
  localparam logic [PHASE_W-1:0] STEP_TOP = PHASE_W'(TABLE_LEN - 1) << FRAC_BITS;
  localparam logic [SUM_W-1:0]   SPAN     = SUM_W'(TABLE_LEN) << FRAC_BITS;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic                     operation;
    logic [ADDR_W-1:0]        table_address;
    logic signed [SAMP_W-1:0] table_value;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMP_W-1:0] sample_out;
    logic                     cycle_start;
  } out_word_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_W-1:0]    addr;
    logic [SAMP_W-1:0]    data;
  } ram_wr_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0] frac;
    logic                 wrap;
  } tick_ctl_t;

  function automatic logic [PHASE_W-1:0] clamp_step(input logic [PHASE_W-1:0] s);
    logic [PHASE_W-1:0] r;
    r = s;
    if (s < STEP_ONE) r = STEP_ONE;
    if (s > STEP_TOP) r = STEP_TOP;
    return r;
  endfunction

  function automatic logic [BAND_W-1:0] pick_band(input logic [PHASE_W-1:0] s);
    logic [BAND_W-1:0] b;
    b = '0;
    for (int unsigned k = 1; k <= BAND_LIMIT; k++) begin
      if (32'(s) >= 32'(k * BAND_DIV)) b = BAND_W'(k);
    end
    return b;
  endfunction

  function automatic logic [ADDR_W-1:0] band_base(input logic [BAND_W-1:0] b);
    logic [ADDR_W-1:0] r;
    r = ADDR_W'(b) * ADDR_W'(TABLE_LEN);
    return r;
  endfunction

endpackage

// ----- hw/rtl/wavetable_oscillator_interp.sv -----
`timescale 1ns / 1ps

// wavetable oscillator with linear interpolation
// input channel (in_valid/in_ready/in_data): a word is either a tick, which
// produces one output sample, or a table write, which loads one 16-bit table
// entry and produces nothing; writes beyond the table are dropped
// output channel (out_valid/out_ready/out_data): interpolated sample plus a
// flag marking the tick on which the phase wrapped past the table end
// cfg_wr_en/cfg_wr_data load the phase step (Q13.16), clamped to
// [1.0, table length - 1]; write it only while no tick is in flight
// a tick's result is registered through the table read, the multiply, then
// rounding into the output register, which drives out_valid
// throughput: one word per cycle while in_ready is high; reads of both neighbor
// samples share the two read ports of the table memory in the same cycle
// a stalled receiver freezes the whole pipeline; in_ready drops only while a
// result is held and out_ready is low
// reset clears the phase, band and pipeline; step returns to 1.0; the table
// itself is not cleared, so every entry must be written before it is read
module wavetable_oscillator_interp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  wto_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output wto_pkg::out_word_t          out_data,
  input  logic                        cfg_wr_en,
  input  logic [wto_pkg::PHASE_W-1:0] cfg_wr_data
);

  logic                        en;
  logic                        accept;
  logic                        tick_go;
  wto_pkg::ram_wr_t            wr;
  wto_pkg::tick_ctl_t          ctl;
  logic [wto_pkg::ADDR_W-1:0]  rd_addr0;
  logic [wto_pkg::ADDR_W-1:0]  rd_addr1;
  logic [wto_pkg::SAMP_W-1:0]  rd_data0;
  logic [wto_pkg::SAMP_W-1:0]  rd_data1;

  assign in_ready = en;
  assign accept   = in_valid && en;
  assign tick_go  = accept && (in_data.operation == wto_pkg::OP_TICK);

  assign wr.en   = accept && (in_data.operation == wto_pkg::OP_WRITE) &&
                   (in_data.table_address < wto_pkg::ADDR_W'(wto_pkg::STORE_DEPTH));
  assign wr.addr = in_data.table_address;
  assign wr.data = in_data.table_value;

  wto_phase u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tick_go     (tick_go),
    .rd_addr0    (rd_addr0),
    .rd_addr1    (rd_addr1),
    .ctl         (ctl)
  );

  wto_table_ram u_ram (
    .clk      (clk),
    .en       (en),
    .wr       (wr),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  wto_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick_go   (tick_go),
    .ctl       (ctl),
    .rd_data0  (rd_data0),
    .rd_data1  (rd_data1),
    .en        (en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/wto_table_ram.sv -----
`timescale 1ns / 1ps

module wto_table_ram (
  input  logic                              clk,
  input  logic                              en,
  input  wto_pkg::ram_wr_t                  wr,
  input  logic [wto_pkg::ADDR_W-1:0]        rd_addr0,
  input  logic [wto_pkg::ADDR_W-1:0]        rd_addr1,
  output logic [wto_pkg::SAMP_W-1:0]        rd_data0,
  output logic [wto_pkg::SAMP_W-1:0]        rd_data1
);

  logic [wto_pkg::SAMP_W-1:0] mem [wto_pkg::STORE_DEPTH];
  logic [wto_pkg::SAMP_W-1:0] rd_data0_r;
  logic [wto_pkg::SAMP_W-1:0] rd_data1_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data0_r <= mem[rd_addr0];
      rd_data1_r <= mem[rd_addr1];
    end
  end

  assign rd_data0 = rd_data0_r;
  assign rd_data1 = rd_data1_r;

endmodule

// ----- hw/rtl/wto_phase.sv -----
`timescale 1ns / 1ps

module wto_phase (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [wto_pkg::PHASE_W-1:0] cfg_wr_data,
  input  logic                        tick_go,
  output logic [wto_pkg::ADDR_W-1:0]  rd_addr0,
  output logic [wto_pkg::ADDR_W-1:0]  rd_addr1,
  output wto_pkg::tick_ctl_t          ctl
);

  logic [wto_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [wto_pkg::PHASE_W-1:0] step_now_r;
  logic [wto_pkg::PHASE_W-1:0] step_cfg_r;
  logic [wto_pkg::BAND_W-1:0]  band_cfg_r;
  logic [wto_pkg::BAND_W-1:0]  band_r;
  logic [wto_pkg::PHASE_W-1:0] cfg_clamped;
  logic [wto_pkg::SUM_W-1:0]   sum;
  logic                        wrap;
  logic [wto_pkg::POS_W-1:0]   pos;
  logic [wto_pkg::POS_W-1:0]   pos_next;
  logic [wto_pkg::ADDR_W-1:0]  base;

  assign cfg_clamped = wto_pkg::clamp_step(cfg_wr_data);

  assign pos      = phase_r[wto_pkg::FRAC_BITS +: wto_pkg::POS_W];
  assign pos_next = (pos == wto_pkg::POS_W'(wto_pkg::TABLE_LEN - 1)) ? '0 : pos + 1'b1;
  assign base     = wto_pkg::band_base(band_r);
  assign rd_addr0 = base + wto_pkg::ADDR_W'(pos);
  assign rd_addr1 = base + wto_pkg::ADDR_W'(pos_next);

  // phase accumulator, one subtract always wraps since step < table length
  always_comb begin
    sum  = wto_pkg::SUM_W'(phase_r) + wto_pkg::SUM_W'(step_now_r);
    wrap = (sum >= wto_pkg::SPAN);
    phase_nxt = wrap ? wto_pkg::PHASE_W'(sum - wto_pkg::SPAN) : wto_pkg::PHASE_W'(sum);
  end

  assign ctl.frac = phase_r[wto_pkg::FRAC_BITS-1:0];
  assign ctl.wrap = wrap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      step_now_r <= wto_pkg::STEP_ONE;
      step_cfg_r <= wto_pkg::STEP_ONE;
      band_cfg_r <= '0;
      band_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        step_cfg_r <= cfg_clamped;
        band_cfg_r <= wto_pkg::pick_band(cfg_clamped);
      end
      if (tick_go) begin
        phase_r    <= phase_nxt;
        step_now_r <= step_cfg_r;
        if (wrap) begin
          band_r <= band_cfg_r;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/wto_interp.sv -----
`timescale 1ns / 1ps

module wto_interp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       tick_go,
  input  wto_pkg::tick_ctl_t         ctl,
  input  logic [wto_pkg::SAMP_W-1:0] rd_data0,
  input  logic [wto_pkg::SAMP_W-1:0] rd_data1,
  output logic                       en,
  output logic                       out_valid,
  input  logic                       out_ready,
  output wto_pkg::out_word_t         out_data
);

  localparam int unsigned DIFF_W = wto_pkg::SAMP_W + 1;
  localparam int unsigned PROD_W = DIFF_W + wto_pkg::FRAC_BITS + 1;
  localparam int unsigned RES_W  = PROD_W - wto_pkg::FRAC_BITS;

  logic                           v1_r;
  logic [wto_pkg::FRAC_BITS-1:0]  frac1_r;
  logic                           wrap1_r;
  logic                           v2_r;
  logic signed [PROD_W-1:0]       prod_r, prod_nxt;
  logic signed [wto_pkg::SAMP_W-1:0] s0_2_r;
  logic                           wrap2_r;
  logic                           out_valid_r;
  wto_pkg::out_word_t             out_data_r, out_data_nxt;

  logic signed [DIFF_W-1:0]       diff;
  logic signed [PROD_W-1:0]       rnd;
  logic signed [RES_W-1:0]        res;

  assign en = !out_valid_r || out_ready;

  // s0 + round((s1 - s0) * f / 2^F), half up
  always_comb begin
    diff     = DIFF_W'($signed(rd_data1)) - DIFF_W'($signed(rd_data0));
    prod_nxt = PROD_W'(diff) * $signed({1'b0, frac1_r});
    rnd      = prod_r + (PROD_W'(1) <<< (wto_pkg::FRAC_BITS - 1));
    res      = RES_W'(s0_2_r) + rnd[PROD_W-1:wto_pkg::FRAC_BITS];
    out_data_nxt.sample_out  = res[wto_pkg::SAMP_W-1:0];
    out_data_nxt.cycle_start = wrap2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= tick_go;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frac1_r    <= ctl.frac;
      wrap1_r    <= ctl.wrap;
      prod_r     <= prod_nxt;
      s0_2_r     <= $signed(rd_data0);
      wrap2_r    <= wrap1_r;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

import wto_pkg::*;

class osc_checker;
  localparam int unsigned BAND_CAP = (NUM_BANDS - 1 < 7) ? NUM_BANDS - 1 : 7;

  logic signed [SAMP_W-1:0] wave_mem [STORE_DEPTH];
  bit                       loaded   [STORE_DEPTH];
  logic [SUM_W-1:0]         phase_acc;
  logic [PHASE_W-1:0]       step_live;
  logic [PHASE_W-1:0]       freq_reg;
  logic [BAND_W-1:0]        band;
  out_word_t                pending_samples[$];
  int unsigned              n_errors;

  function new();
    phase_acc = '0;
    step_live = STEP_ONE;
    freq_reg  = STEP_ONE;
    band      = '0;
    n_errors  = 0;
    foreach (loaded[i]) loaded[i] = 1'b0;
  endfunction

  function int pending();
    return pending_samples.size();
  endfunction

  function void set_freq(logic [PHASE_W-1:0] v);
    freq_reg = v;
  endfunction

  function bit is_loaded(int unsigned a);
    return loaded[a];
  endfunction

  function logic [PHASE_W-1:0] eff_step();
    if (freq_reg < STEP_ONE) return STEP_ONE;
    if (freq_reg > STEP_TOP) return STEP_TOP;
    return freq_reg;
  endfunction

  function logic [BAND_W-1:0] band_for(logic [PHASE_W-1:0] s);
    longint unsigned q;
    q = (64'(s) * 64'(FREQ_MUL)) / (64'(FREQ_DIV) << FRAC_BITS);
    if (q > 64'(BAND_CAP)) q = 64'(BAND_CAP);
    return BAND_W'(q);
  endfunction

  // table words read by the next tick: sample at the phase and its neighbor
  function void read_addrs(output int unsigned a0, output int unsigned a1);
    int unsigned pos;
    int unsigned nxt;
    pos = 32'(phase_acc >> FRAC_BITS);
    nxt = (pos + 1 < TABLE_LEN) ? pos + 1 : 0;
    a0  = 32'(band) * TABLE_LEN + pos;
    a1  = 32'(band) * TABLE_LEN + nxt;
  endfunction

  function out_word_t predict_tick();
    out_word_t            r;
    int unsigned          a0;
    int unsigned          a1;
    logic [FRAC_BITS-1:0] frac;
    longint               acc;
    read_addrs(a0, a1);
    frac = phase_acc[FRAC_BITS-1:0];
    acc  = longint'(wave_mem[a0]) * ((longint'(1) << FRAC_BITS) - longint'(frac))
         + longint'(wave_mem[a1]) * longint'(frac);
    // round half up
    acc  = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    r.sample_out  = acc[SAMP_W-1:0];
    r.cycle_start = 1'b0;
    phase_acc = phase_acc + SUM_W'(step_live);
    if (phase_acc >= SPAN) begin
      phase_acc     = phase_acc - SPAN;
      r.cycle_start = 1'b1;
      band          = band_for(eff_step());
    end
    step_live = eff_step();
    return r;
  endfunction

  function void note_word(in_word_t w);
    if (w.operation == OP_WRITE) begin
      if (32'(w.table_address) < STORE_DEPTH) begin
        wave_mem[w.table_address] = w.table_value;
        loaded[w.table_address]   = 1'b1;
      end
    end else begin
      pending_samples.push_back(predict_tick());
    end
  endfunction

  task flag_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  task check_sample(out_word_t got);
    out_word_t want;
    if (pending_samples.size() == 0) begin
      flag_mismatch($sformatf("unexpected word, sample %0d", got.sample_out));
      return;
    end
    want = pending_samples.pop_front();
    if (got.sample_out !== want.sample_out)
      flag_mismatch($sformatf("sample_out got %0d want %0d", got.sample_out, want.sample_out));
    if (got.cycle_start !== want.cycle_start)
      flag_mismatch($sformatf("cycle_start got %0b want %0b", got.cycle_start,
                              want.cycle_start));
  endtask
endclass

module testbench;
  localparam int unsigned LONG_HOLD_CYCLES = 200;
  localparam int unsigned DRAIN_LIMIT      = 5000;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned NUM_PHASES       = 14;
  localparam int unsigned PHASE_ITEMS      = 70;

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  in_word_t           in_data     = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  out_word_t          out_data;
  logic               cfg_wr_en   = 1'b0;
  logic [PHASE_W-1:0] cfg_wr_data = '0;

  int unsigned idle_pct  = 10;
  bit          long_hold = 1'b0;
  osc_checker  sb;

  wavetable_oscillator_interp u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // receiver side
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // inputs only change at the rising edge, so the mid-cycle sample is what the edge takes
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_sample(out_data);
  end

  task automatic write_freq(logic [PHASE_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_freq(v);
  endtask

  task automatic send_word(in_word_t w);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sb.note_word(w);
  endtask

  function automatic logic signed [SAMP_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return SAMP_W'($urandom);
    endcase
  endfunction

  task automatic load_word(logic [ADDR_W-1:0] addr, logic signed [SAMP_W-1:0] val);
    in_word_t w;
    w.operation     = OP_WRITE;
    w.table_address = addr;
    w.table_value   = val;
    send_word(w);
  endtask

  // never read a table word that has not been loaded
  task automatic tick();
    in_word_t    w;
    int unsigned a0;
    int unsigned a1;
    sb.read_addrs(a0, a1);
    if (!sb.is_loaded(a0)) load_word(ADDR_W'(a0), rand_sample());
    if (!sb.is_loaded(a1)) load_word(ADDR_W'(a1), rand_sample());
    w.operation     = OP_TICK;
    w.table_address = ADDR_W'($urandom);
    w.table_value   = SAMP_W'($urandom);
    send_word(w);
  endtask

  task automatic random_item();
    int unsigned a0;
    int unsigned a1;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    sb.read_addrs(a0, a1);
    if (sel < 55)
      tick();
    else if (sel < 75)
      load_word(ADDR_W'($urandom_range(0, 1) ? a0 : a1), rand_sample());
    else if (sel < 92)
      load_word(ADDR_W'($urandom_range(0, STORE_DEPTH - 1)), rand_sample());
    else
      load_word(ADDR_W'($urandom_range(STORE_DEPTH, 16'hFFFF)), rand_sample());
  endtask

  function automatic logic [PHASE_W-1:0] pick_freq();
    case ($urandom_range(0, 5))
      0:       return PHASE_W'($urandom_range(0, STEP_ONE - 1));
      1:       return PHASE_W'($urandom);
      2, 3:    return PHASE_W'($urandom_range(STEP_ONE, 32'd7_000_000));
      4:       return PHASE_W'($urandom_range(STEP_ONE, STEP_TOP));
      default: return PHASE_W'($urandom_range(STEP_ONE, 4 * STEP_ONE));
    endcase
  endfunction

  task automatic settle();
    int unsigned waited;
    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned p;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // step 1.5: exact sample, half-way rounding, end of table, dropped writes
    write_freq(PHASE_W'(32'h0001_8000));
    load_word(16'd0, 16'sh7FFF);
    load_word(16'd1, 16'sh8000);
    load_word(16'd2, -16'sd1);
    load_word(16'd3, 16'sd0);
    load_word(ADDR_W'(STORE_DEPTH - 1), 16'sh7FFF);
    load_word(ADDR_W'(STORE_DEPTH), rand_sample());
    load_word(16'hFFFF, 16'sh8000);
    repeat (5) tick();
    settle();
    // step above the table, below 1.0, at the top and at 1.0
    write_freq('1);
    repeat (4) tick();
    settle();
    write_freq('0);
    repeat (3) tick();
    settle();
    write_freq(STEP_TOP);
    repeat (3) tick();
    settle();
    write_freq(STEP_ONE);
    repeat (2) tick();
    settle();

    for (p = 0; p < NUM_PHASES; p++) begin
      write_freq(pick_freq());
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 30;
      endcase
      if (p >= NUM_PHASES - 2) idle_pct = 0;
      if (p == 3) long_hold = 1'b1;
      repeat (PHASE_ITEMS) random_item();
      settle();
    end

    if (sb.pending() != 0)
      sb.flag_mismatch($sformatf("%0d samples never arrived", sb.pending()));
    if (sb.n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/wto_pkg.sv
hw/rtl/wto_table_ram.sv
hw/rtl/wto_phase.sv
hw/rtl/wto_interp.sv
hw/rtl/wavetable_oscillator_interp.sv
verif/testbench.sv
